// ===== hdl/b2a_pkg.sv =====
`default_nettype none

package b2a_pkg;

  typedef logic [3:0] digit_t;
  typedef digit_t [4:0] dgroup_t;

  typedef struct packed {
    digit_t tens;
    digit_t units;
  } pair_t;

  localparam logic [2:0] KIND_DEC8  = 3'd0;
  localparam logic [2:0] KIND_DEC16 = 3'd1;
  localparam logic [2:0] KIND_DEC32 = 3'd2;
  localparam logic [2:0] KIND_HEX8  = 3'd3;
  localparam logic [2:0] KIND_HEX16 = 3'd4;

  localparam logic [3:0] LEN_DEC8  = 4'd3;
  localparam logic [3:0] LEN_DEC16 = 4'd5;
  localparam logic [3:0] LEN_DEC32 = 4'd10;
  localparam logic [3:0] LEN_HEX8  = 4'd2;
  localparam logic [3:0] LEN_HEX16 = 4'd4;

  // value / 100000 == (value * DIV_GROUP_MUL) >> DIV_GROUP_SHIFT for 32-bit value
  localparam logic [32:0] DIV_GROUP_MUL   = 33'd5629499535;
  localparam int          DIV_GROUP_SHIFT = 49;
  localparam logic [16:0] GROUP_SPAN      = 17'd100000;

  // g / 1000 == (g * DIV_THOU_MUL) >> 27 for 17-bit g
  localparam logic [17:0] DIV_THOU_MUL = 18'd134218;
  localparam logic [16:0] THOUSAND     = 17'd1000;

  // b / 100 == (b * 41) >> 12 for b < 1000
  localparam logic [15:0] DIV_HUND_MUL = 16'd41;
  localparam logic [9:0]  HUNDRED      = 10'd100;

  localparam logic [6:0] CHAR_ZERO  = 7'h30;
  localparam logic [5:0] CHAR_ZERO6 = 6'h30;
  localparam logic [6:0] CHAR_HEX_A = 7'h37;

  // two-digit split, small enough to map to a lookup
  function automatic pair_t split_pair(input logic [6:0] x);
    logic [14:0] prod;
    logic [6:0]  rem;
    pair_t       p;
    prod    = 15'(x) * 15'd205;
    p.tens  = prod[14:11];
    rem     = x - 7'(p.tens) * 7'd10;
    p.units = rem[3:0];
    return p;
  endfunction

  function automatic logic [6:0] dec_char7(input digit_t d);
    return CHAR_ZERO + {3'b000, d};
  endfunction

  function automatic logic [5:0] dec_char6(input digit_t d);
    return CHAR_ZERO6 + {2'b00, d};
  endfunction

  function automatic logic [6:0] hex_char(input digit_t d);
    logic [6:0] c;
    if (d > 4'd9) begin
      c = CHAR_HEX_A + {3'b000, d};
    end else begin
      c = CHAR_ZERO + {3'b000, d};
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/b2a_dgroup.sv =====
`default_nettype none

module b2a_dgroup import b2a_pkg::*; (
  input  wire logic        clk,
  input  wire logic [16:0] grp,
  output dgroup_t          digits
);

  logic [34:0] thou_prod;
  logic [6:0]  thou3;
  logic [16:0] grp3;

  logic [16:0] rem_wide;
  logic [6:0]  thou4;
  logic [9:0]  low4;

  logic [15:0] hund_prod;
  pair_t       thou_pair5;
  digit_t      hund5;
  logic [9:0]  low5;

  logic [9:0]  rem_low;
  pair_t       thou_pair6;
  digit_t      hund6;
  logic [6:0]  tail6;

  pair_t       tail_pair;

  // stage 3: thousands quotient
  assign thou_prod = 35'(grp) * 35'(DIV_THOU_MUL);

  always_ff @(posedge clk) begin
    thou3 <= thou_prod[33:27];
    grp3  <= grp;
  end

  // stage 4: remainder below one thousand
  assign rem_wide = grp3 - 17'(thou3) * THOUSAND;

  always_ff @(posedge clk) begin
    thou4 <= thou3;
    low4  <= rem_wide[9:0];
  end

  // stage 5: hundreds digit, upper pair split
  assign hund_prod = 16'(low4) * DIV_HUND_MUL;

  always_ff @(posedge clk) begin
    thou_pair5 <= split_pair(thou4);
    hund5      <= hund_prod[15:12];
    low5       <= low4;
  end

  // stage 6: last two digits
  assign rem_low = low5 - 10'(hund5) * HUNDRED;

  always_ff @(posedge clk) begin
    thou_pair6 <= thou_pair5;
    hund6      <= hund5;
    tail6      <= rem_low[6:0];
  end

  assign tail_pair = split_pair(tail6);

  assign digits[4] = thou_pair6.tens;
  assign digits[3] = thou_pair6.units;
  assign digits[2] = hund6;
  assign digits[1] = tail_pair.tens;
  assign digits[0] = tail_pair.units;

endmodule

`default_nettype wire

// ===== hdl/binary_to_ascii_digits_unit.sv =====
// channel   signals                               handshake
// request   kind, value                           taken when start && !busy
// result    char_0 .. char_9, char_count          strobe high for one cycle
//
// one request per clock, busy is high only while rst is
// fixed pipeline: input register, the numbered stages and the output register;
// the depth is set by the /100000, /1000 and /100 reciprocal multiplies
// rst (synchronous) empties the pipeline, no strobe follows it
// the receiver cannot stall, so nothing ever backs up
`default_nettype none

module binary_to_ascii_digits_unit import b2a_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  kind,
  input  wire logic [31:0] value,
  output logic             strobe,
  output logic [6:0]       char_0,
  output logic [6:0]       char_1,
  output logic [6:0]       char_2,
  output logic [6:0]       char_3,
  output logic [6:0]       char_4,
  output logic [5:0]       char_5,
  output logic [5:0]       char_6,
  output logic [5:0]       char_7,
  output logic [5:0]       char_8,
  output logic [5:0]       char_9,
  output logic [3:0]       char_count
);

  logic [6:0]  vld;

  logic [2:0]  kind0;
  logic [31:0] value0;

  logic [31:0] vmask;
  logic [64:0] grp_prod;
  logic [31:0] val1;
  logic [15:0] quo1;

  logic [31:0] hi_scaled;
  logic [31:0] lo_wide;
  logic [16:0] hi2;
  logic [16:0] lo2;

  logic [2:0]  kind_d [1:6];
  logic [15:0] hex_d [2:6];

  dgroup_t     hi_dig;
  dgroup_t     lo_dig;

  logic [6:0]  c7_next [0:4];
  logic [5:0]  c6_next [5:9];
  logic [3:0]  count_next;

  assign busy = rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      strobe <= 1'b0;
    end else begin
      vld    <= {vld[5:0], start & ~busy};
      strobe <= vld[6];
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      kind0  <= kind;
      value0 <= value;
    end
  end

  // stage 1: mask to kind width, quotient by 100000
  always_comb begin
    case (kind0)
      KIND_DEC8, KIND_HEX8:   vmask = {24'd0, value0[7:0]};
      KIND_DEC16, KIND_HEX16: vmask = {16'd0, value0[15:0]};
      default:                vmask = value0;
    endcase
  end

  assign grp_prod = 65'(vmask) * 65'(DIV_GROUP_MUL);

  always_ff @(posedge clk) begin
    val1      <= vmask;
    quo1      <= grp_prod[DIV_GROUP_SHIFT +: 16];
    kind_d[1] <= kind0;
  end

  // stage 2: split into two five-digit groups
  assign hi_scaled = 32'(quo1) * 32'(GROUP_SPAN);
  assign lo_wide   = val1 - hi_scaled;

  always_ff @(posedge clk) begin
    hi2       <= 17'(quo1);
    lo2       <= lo_wide[16:0];
    kind_d[2] <= kind_d[1];
    hex_d[2]  <= val1[15:0];
  end

  always_ff @(posedge clk) begin
    for (int i = 3; i <= 6; i++) begin
      kind_d[i] <= kind_d[i-1];
      hex_d[i]  <= hex_d[i-1];
    end
  end

  b2a_dgroup u_hi_group (
    .clk    (clk),
    .grp    (hi2),
    .digits (hi_dig)
  );

  b2a_dgroup u_lo_group (
    .clk    (clk),
    .grp    (lo2),
    .digits (lo_dig)
  );

  // output assembly
  always_comb begin
    for (int i = 0; i <= 4; i++) begin
      c7_next[i] = '0;
    end
    for (int i = 5; i <= 9; i++) begin
      c6_next[i] = '0;
    end
    count_next = '0;
    case (kind_d[6])
      KIND_DEC8: begin
        c7_next[0] = dec_char7(lo_dig[2]);
        c7_next[1] = dec_char7(lo_dig[1]);
        c7_next[2] = dec_char7(lo_dig[0]);
        count_next = LEN_DEC8;
      end
      KIND_DEC16: begin
        for (int i = 0; i <= 4; i++) begin
          c7_next[i] = dec_char7(lo_dig[4-i]);
        end
        count_next = LEN_DEC16;
      end
      KIND_DEC32: begin
        for (int i = 0; i <= 4; i++) begin
          c7_next[i] = dec_char7(hi_dig[4-i]);
        end
        for (int i = 5; i <= 9; i++) begin
          c6_next[i] = dec_char6(lo_dig[9-i]);
        end
        count_next = LEN_DEC32;
      end
      KIND_HEX8: begin
        c7_next[0] = hex_char(hex_d[6][7:4]);
        c7_next[1] = hex_char(hex_d[6][3:0]);
        count_next = LEN_HEX8;
      end
      KIND_HEX16: begin
        c7_next[0] = hex_char(hex_d[6][15:12]);
        c7_next[1] = hex_char(hex_d[6][11:8]);
        c7_next[2] = hex_char(hex_d[6][7:4]);
        c7_next[3] = hex_char(hex_d[6][3:0]);
        count_next = LEN_HEX16;
      end
      default: begin
        count_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    char_0     <= c7_next[0];
    char_1     <= c7_next[1];
    char_2     <= c7_next[2];
    char_3     <= c7_next[3];
    char_4     <= c7_next[4];
    char_5     <= c6_next[5];
    char_6     <= c6_next[6];
    char_7     <= c6_next[7];
    char_8     <= c6_next[8];
    char_9     <= c6_next[9];
    char_count <= count_next;
  end

endmodule

`default_nettype wire

// ===== tb/binary_to_ascii_digits_unit_test.sv =====
`timescale 1ns / 1ps

module binary_to_ascii_digits_unit_test;
  import b2a_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_REQUESTS = 1900;
  localparam logic [6:0] ASCII_DIGIT_ZERO = 7'h30;
  localparam logic [6:0] ASCII_UPPER_A = 7'h41;

  typedef struct packed {
    logic [9:0][6:0] chars;
    logic [3:0]      count;
  } text_t;

  typedef struct {
    logic [2:0]  kind;
    logic [31:0] value;
    int          gap;
    bit          hold;
  } request_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [2:0] kind = '0;
  logic [31:0] value = '0;
  logic busy;
  logic strobe;
  logic [6:0] char_0, char_1, char_2, char_3, char_4;
  logic [5:0] char_5, char_6, char_7, char_8, char_9;
  logic [3:0] char_count;

  request_t pending_requests[$];
  text_t expected_text[$];
  int idle_count = 0;
  int error_count = 0;
  int cycle_count = 0;

  binary_to_ascii_digits_unit uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .kind(kind),
    .value(value),
    .strobe(strobe),
    .char_0(char_0),
    .char_1(char_1),
    .char_2(char_2),
    .char_3(char_3),
    .char_4(char_4),
    .char_5(char_5),
    .char_6(char_6),
    .char_7(char_7),
    .char_8(char_8),
    .char_9(char_9),
    .char_count(char_count)
  );

  always #10 clk = ~clk;

  function automatic text_t render_text(input logic [2:0] k, input logic [31:0] v);
    text_t       r;
    logic [31:0] x;
    int unsigned radix;
    int unsigned d;
    int          i;
    r = '0;
    x = v;
    radix = 10;
    case (k)
      KIND_DEC8: begin
        x = {24'd0, v[7:0]};
        r.count = LEN_DEC8;
      end
      KIND_DEC16: begin
        x = {16'd0, v[15:0]};
        r.count = LEN_DEC16;
      end
      KIND_DEC32: begin
        r.count = LEN_DEC32;
      end
      KIND_HEX8: begin
        x = {24'd0, v[7:0]};
        radix = 16;
        r.count = LEN_HEX8;
      end
      KIND_HEX16: begin
        x = {16'd0, v[15:0]};
        radix = 16;
        r.count = LEN_HEX16;
      end
      default: begin
        r.count = '0;
      end
    endcase
    for (i = int'(r.count) - 1; i >= 0; i--) begin
      d = x % radix;
      x = x / radix;
      if (d > 9) begin
        r.chars[i] = ASCII_UPPER_A + 7'(d - 10);
      end else begin
        r.chars[i] = ASCII_DIGIT_ZERO + 7'(d);
      end
    end
    return r;
  endfunction

  task automatic add_request(input logic [2:0] k, input logic [31:0] v, input int gap,
                             input bit hold);
    request_t req;
    req.kind = k;
    req.value = v;
    req.gap = gap;
    req.hold = hold;
    pending_requests = {pending_requests, req};
  endtask

  // request driver
  always @(posedge clk) begin
    request_t head;
    logic     go;
    if (rst) begin
      start <= 1'b0;
      idle_count <= 0;
    end else begin
      go = start;
      if (start && !busy) begin
        expected_text = {expected_text, render_text(kind, value)};
        go = 1'b0;
      end
      if (!go && pending_requests.size() != 0) begin
        head = pending_requests[0];
        if (head.hold && expected_text.size() != 0) begin
          go = 1'b0;
        end else if (idle_count < head.gap) begin
          idle_count <= idle_count + 1;
        end else begin
          void'(pending_requests.pop_front());
          kind <= head.kind;
          value <= head.value;
          idle_count <= 0;
          go = 1'b1;
        end
      end
      start <= go;
    end
  end

  // result monitor
  always @(posedge clk) begin
    text_t           want;
    logic [9:0][6:0] got;
    int              j;
    if (!rst && strobe) begin
      got = {{1'b0, char_9}, {1'b0, char_8}, {1'b0, char_7}, {1'b0, char_6},
             {1'b0, char_5}, char_4, char_3, char_2, char_1, char_0};
      if (expected_text.size() == 0) begin
        error_count++;
        $display("%0t: result with no request pending, char_count %0d", $time, char_count);
      end else begin
        want = expected_text.pop_front();
        for (j = 0; j < 10; j++) begin
          if (got[j] !== want.chars[j]) begin
            error_count++;
            $display("%0t: char_%0d expected %0d actual %0d", $time, j, want.chars[j],
                     got[j]);
          end
        end
        if (char_count !== want.count) begin
          error_count++;
          $display("%0t: char_count expected %0d actual %0d", $time, want.count,
                   char_count);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    int unsigned powers[10];
    int          n;
    int          mode;
    int          gap;
    int unsigned pick;
    logic [2:0]  k;
    logic [31:0] v;

    powers = '{1, 10, 100, 1000, 10000, 100000, 1000000, 10000000, 100000000,
               1000000000};

    // field extremes for every format
    add_request(KIND_DEC8, 32'd0, 0, 1'b0);
    add_request(KIND_DEC8, 32'd255, 0, 1'b0);
    add_request(KIND_DEC8, 32'hFFFF_FF00, 1, 1'b0);
    add_request(KIND_DEC8, 32'h0000_01FF, 0, 1'b0);
    add_request(KIND_DEC16, 32'd0, 0, 1'b0);
    add_request(KIND_DEC16, 32'd65535, 0, 1'b0);
    add_request(KIND_DEC16, 32'hFFFF_FFFF, 2, 1'b0);
    add_request(KIND_DEC32, 32'd0, 0, 1'b0);
    add_request(KIND_DEC32, 32'hFFFF_FFFF, 0, 1'b0);
    add_request(KIND_DEC32, 32'd1000000000, 0, 1'b0);
    add_request(KIND_DEC32, 32'd999999999, 0, 1'b0);
    add_request(KIND_DEC32, 32'd100000, 3, 1'b0);
    add_request(KIND_HEX8, 32'd0, 0, 1'b0);
    add_request(KIND_HEX8, 32'hFFFF_FFFF, 0, 1'b0);
    add_request(KIND_HEX8, 32'h0000_0F9A, 0, 1'b0);
    add_request(KIND_HEX16, 32'd0, 0, 1'b0);
    add_request(KIND_HEX16, 32'hFFFF_FFFF, 0, 1'b0);
    add_request(KIND_HEX16, 32'h1234_ABCD, 0, 1'b0);
    add_request(KIND_HEX16, 32'h0000_9F0A, 5, 1'b0);
    // unused format codes
    add_request(3'd5, 32'hFFFF_FFFF, 0, 1'b0);
    add_request(3'd6, 32'd12345, 0, 1'b0);
    add_request(3'd7, 32'h8000_0001, 0, 1'b0);

    mode = 0;
    for (n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n % 64 == 0) begin
        mode = $urandom_range(0, 2);
      end
      case (mode)
        0: gap = 0;
        1: gap = $urandom_range(0, 16);
        default: gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16) : 0;
      endcase
      pick = $urandom_range(0, 15);
      if (pick < 14) begin
        k = 3'($urandom_range(0, 4));
      end else begin
        k = 3'($urandom_range(5, 7));
      end
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: v = $urandom;
        5: v = $urandom_range(0, 255);
        6: v = $urandom_range(0, 65535);
        7: v = powers[$urandom_range(0, 9)] - 32'($urandom_range(0, 2)) + 32'd1;
        8: v = ($urandom & 32'hFFFF_0000) | 32'($urandom_range(65500, 65535));
        default: v = ($urandom_range(0, 1) == 1) ? 32'hFFFF_FFFF : 32'd0;
      endcase
      // drain everything before a few requests
      add_request(k, v, gap, (n == 0) || (n == RANDOM_REQUESTS / 2) || (n == 1500));
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    while (pending_requests.size() != 0 || start || expected_text.size() != 0) begin
      @(posedge clk);
    end
    repeat (20) @(posedge clk);

    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
